[hdl/sps_pkg.sv]
// Package for the systolic prime sieve: sizes, the bit-serial item token
// passed between filter cells. No dependencies.
package sps_pkg;

  localparam int NUM_CELLS  = 16;
  localparam int VALUE_BITS = 16;
  localparam int DATA_W     = 16;
  localparam int CNT_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(VALUE_BITS - 1);

  // One beat of an item moving down the row, value bits MSB first.
  typedef struct packed {
    logic vld;
    logic bit_val;
    logic first;   // first beat of the item
    logic clr;     // start of run; cells act on it only on the first beat
    logic last;    // last beat; alive/found are final here
    logic alive;   // not dropped yet and not claimed
    logic found;   // claimed by an empty cell as a new prime
  } sps_token_t;

endpackage

[hdl/sps_cell.sv]
// One filter cell of the sieve: holds a prime, computes value mod prime one
// bit per beat, and claims the item when empty. Depends on sps_pkg.
module sps_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  sps_pkg::sps_token_t tok_i,
  output sps_pkg::sps_token_t tok_o
);
  import sps_pkg::*;

  logic [VALUE_BITS-1:0] prime_r, prime_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic                  full_r, full_nxt;
  sps_token_t            tok_r, tok_nxt;

  logic                  eff_full;
  logic [VALUE_BITS-1:0] rem_in;
  logic [VALUE_BITS:0]   trial;
  logic                  divides;

  always_comb begin
    eff_full  = full_r && !(tok_i.first && tok_i.clr);
    rem_in    = tok_i.first ? '0 : rem_r;
    trial     = {rem_in, tok_i.bit_val};
    if (trial >= {1'b0, prime_r}) begin
      trial = trial - {1'b0, prime_r};
    end
    rem_nxt   = trial[VALUE_BITS-1:0];
    divides   = eff_full && (rem_nxt == '0);

    prime_nxt = prime_r;
    full_nxt  = full_r;
    tok_nxt   = tok_i;
    if (tok_i.vld) begin
      full_nxt = eff_full;
      // an empty cell collects the value bits as its candidate prime
      if (!eff_full) begin
        prime_nxt = {prime_r[VALUE_BITS-2:0], tok_i.bit_val};
      end
      if (tok_i.last) begin
        tok_nxt.alive = tok_i.alive && eff_full && !divides;
        tok_nxt.found = tok_i.found || (tok_i.alive && !eff_full);
        if (tok_i.alive && !eff_full) begin
          full_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      tok_r  <= '0;
    end else if (en) begin
      full_r <= full_nxt;
      tok_r  <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok_i.vld) begin
      prime_r <= prime_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

[hdl/systolic_prime_sieve.sv]
// Systolic prime sieve: an item is serialized MSB first and its bits walk a
// row of NUM_CELLS filter cells, one cell per cycle unless the row stalls. A
// new item is taken once the feeder has sent every bit of the last one, while
// earlier items still pass down the row; each cell registers the beat it passes.
// A held result stalls the row only when the next result reaches the tail.
// Synchronous active-low reset empties all cells and drops items in flight.
module systolic_prime_sieve (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sps_pkg::DATA_W-1:0] in_tdata,  // [15:0] value
  input  logic [0:0]                 in_tuser,  // [0] start_of_run
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sps_pkg::DATA_W-1:0] out_tdata, // [15:0] prime
  output logic [0:0]                 out_tuser  // [0] overflow
);
  import sps_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [VALUE_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  first_r, first_nxt;
  logic                  clr_r, alive_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_data_r;
  logic                  out_ovf_r;

  sps_token_t            chain [NUM_CELLS+1];
  sps_token_t            tail;
  logic                  tail_res;
  logic                  en;
  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] tail_val;

  assign tail     = chain[NUM_CELLS];
  assign tail_res = tail.vld && tail.last && (tail.alive || tail.found);
  assign en       = !(tail_res && out_valid_r && !out_tready);
  assign in_val   = VALUE_BITS'(in_tdata);
  assign tail_val = {acc_r[VALUE_BITS-2:0], tail.bit_val};

  assign in_tready = !busy_r;

  // feeder: one value bit per beat into cell 0
  always_comb begin
    chain[0].vld     = busy_r;
    chain[0].bit_val = shift_r[VALUE_BITS-1];
    chain[0].first   = first_r;
    chain[0].clr     = clr_r;
    chain[0].last    = (cnt_r == LAST_BEAT);
    chain[0].alive   = alive_r;
    chain[0].found   = 1'b0;
  end

  always_comb begin
    busy_nxt  = busy_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (in_tvalid && in_tready) begin
      busy_nxt  = 1'b1;
      shift_nxt = in_val;
      cnt_nxt   = '0;
      first_nxt = 1'b1;
    end else if (busy_r && en) begin
      shift_nxt = {shift_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
      first_nxt = 1'b0;
      if (cnt_r == LAST_BEAT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    if (in_tvalid && in_tready) begin
      clr_r   <= in_tuser[0];
      // values below two pass the row only to carry a start of run
      alive_r <= (in_val >= VALUE_BITS'(2));
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sps_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  // collector: rebuild the value at the tail, hold one result
  always_ff @(posedge clk) begin
    if (en && tail.vld) begin
      acc_r <= tail_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && tail_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tail_res) begin
      out_data_r <= DATA_W'(tail_val);
      out_ovf_r  <= tail.alive;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ovf_r;

  a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(in_tvalid && in_tready))
    else $error("feeder started without an accepted item");

  a_last_beat_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && en && cnt_r == LAST_BEAT) |=> !busy_r)
    else $error("feeder ran past the last beat");

  a_tail_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.vld && tail.last) |-> !(tail.alive && tail.found))
    else $error("item both claimed and still alive at tail");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (en && tail_res) |-> (!out_valid_r || out_tready))
    else $error("held result overwritten");

endmodule

[verif/tb_systolic_prime_sieve.sv]
// Self-checking testbench for systolic_prime_sieve: directed and random item
// streams, a shadow row of filter cells that predicts each result, stream stalls.
// Depends on sps_pkg and the systolic_prime_sieve RTL.
module tb_systolic_prime_sieve;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int          TAIL_CYCLES = VALUE_BITS + NUM_CELLS + 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    logic [DATA_W-1:0] prime;
    logic              overflow;
  } prime_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic [0:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic [0:0]        out_tuser;

  // shadow copy of the filter row
  logic [VALUE_BITS-1:0] held_prime [NUM_CELLS];
  bit                    held_full  [NUM_CELLS];

  prime_result_t pending_primes[$];
  prime_result_t head_result;

  int          burst_left;
  int          hold_left;
  int          items_sent;
  int          live_items;
  int          prime_count;
  int          overflow_count;
  int          mismatch_count;
  int unsigned cycle_count;

  systolic_prime_sieve DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_primes.size());
      $display("tb_systolic_prime_sieve: done, errors");
      $finish;
    end
  end

  // Walk the shadow row; returns 1 when the item yields a result.
  function automatic bit sieve_predict(input logic [DATA_W-1:0] value, input bit run_start,
                                       output prime_result_t res);
    logic [VALUE_BITS-1:0] v;
    v = value[VALUE_BITS-1:0];
    res.prime    = '0;
    res.overflow = 1'b0;
    if (run_start) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        held_prime[i] = '0;
        held_full[i]  = 1'b0;
      end
    end
    if (v < 2) return 1'b0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (!held_full[i]) begin
        held_prime[i] = v;
        held_full[i]  = 1'b1;
        res.prime     = DATA_W'(v);
        return 1'b1;
      end
      if (held_prime[i] != 0 && (v % held_prime[i]) == 0) return 1'b0;
    end
    res.prime    = DATA_W'(v);
    res.overflow = 1'b1;
    return 1'b1;
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_primes.size() == 0) begin
        note_error($sformatf("unexpected item prime=%0d overflow=%0b", out_tdata,
                             out_tuser[0]));
      end else begin
        head_result = pending_primes.pop_front();
        if (out_tdata !== head_result.prime || out_tuser[0] !== head_result.overflow)
          note_error($sformatf("expected prime=%0d overflow=%0b, got prime=%0d overflow=%0b",
                               head_result.prime, head_result.overflow, out_tdata,
                               out_tuser[0]));
        if (head_result.overflow) overflow_count++;
        else prime_count++;
      end
    end
  end

  // Receiver: a long hold when asked, otherwise switches among stall patterns.
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       rx_phase;
    out_tready = 1'b0;
    rx_mode    = RX_OPEN;
    mode_left  = 0;
    rx_phase   = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: begin
            out_tready <= 1'b1;
          end
          RX_RANDOM: begin
            out_tready <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            out_tready <= ((rx_phase % 7) < 4);
            rx_phase++;
          end
        endcase
      end
    end
  end

  // Offer one item, in bursts with random gaps; predict on acceptance.
  task automatic send_item(input logic [DATA_W-1:0] value, input bit run_start);
    prime_result_t res;
    int            gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    @(negedge clk);
    in_tvalid   <= 1'b1;
    in_tdata    <= value;
    in_tuser[0] <= run_start;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
    if (value[VALUE_BITS-1:0] >= 2) live_items++;
    if (sieve_predict(value, run_start, res)) pending_primes.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_primes.size() != 0) @(posedge clk);
  endtask

  task automatic test_low_values();
    send_item(16'd0, 1'b1);   // clears row, nothing reported
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd2, 1'b0);   // repeat of a held prime
    send_item(16'd4, 1'b0);
    send_item(16'd3, 1'b0);
  endtask

  task automatic test_extremes();
    send_item(16'hFFFF, 1'b0); // multiple of 3, dropped
    send_item(16'hFFFF, 1'b1);
    send_item(16'h8000, 1'b0);
  endtask

  task automatic test_row_full();
    int unsigned first_primes [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                                       47, 53};
    for (int i = 0; i < NUM_CELLS; i++) send_item(DATA_W'(first_primes[i % 16]), i == 0);
    send_item(16'd59, 1'b0);    // no free cell left
    send_item(16'd4, 1'b0);
    send_item(16'd65521, 1'b0);
  endtask

  task automatic test_unordered();
    send_item(16'd9, 1'b1);     // composite taken as prime
    send_item(16'd3, 1'b0);
    send_item(16'd27, 1'b0);
    send_item(16'd15, 1'b0);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering items.
  task automatic test_long_hold();
    wait_drained();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_item(DATA_W'(2 + i), i == 0);
    wait_drained();
  endtask

  task automatic test_random_streams(input int target);
    int          base_live;
    int          run_len;
    int          kind;
    int          step;
    logic [15:0] v;
    base_live = live_items;
    while (live_items - base_live < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // counter-fed run from 2, the normal use
        run_len = $urandom_range(5, 150);
        for (int i = 0; i < run_len; i++) send_item(DATA_W'(2 + i), i == 0);
      end else if (kind == 6) begin
        v       = 16'($urandom);
        run_len = $urandom_range(5, 60);
        for (int i = 0; i < run_len; i++) send_item(v + 16'(i), i == 0);
      end else if (kind == 7) begin
        v       = 16'($urandom);
        run_len = $urandom_range(5, 40);
        for (int i = 0; i < run_len; i++) send_item(v - 16'(i), i == 0);
      end else if (kind == 8) begin
        run_len = $urandom_range(1, 30);
        for (int i = 0; i < run_len; i++)
          send_item(16'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        // no start flag, skips, an occasional restart mid-run
        v       = 16'($urandom_range(0, 20));
        run_len = $urandom_range(5, 80);
        for (int i = 0; i < run_len; i++) begin
          send_item(v, $urandom_range(0, 24) == 0);
          step = $urandom_range(1, 3);
          v    = v + 16'(step);
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    burst_left     = 0;
    hold_left      = 0;
    items_sent     = 0;
    live_items     = 0;
    prime_count    = 0;
    overflow_count = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      held_prime[i] = '0;
      held_full[i]  = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_low_values();
    test_extremes();
    test_row_full();
    test_unordered();
    test_long_hold();
    test_random_streams(1750);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_primes.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_primes.size()));

    $display("sent %0d items (%0d of value 2 or more) over %0d cycles", items_sent,
             live_items, cycle_count);
    $display("checked %0d new primes and %0d row overflows, %0d mismatches", prime_count,
             overflow_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_systolic_prime_sieve: done, clean");
    end else begin
      $display("tb_systolic_prime_sieve: done, errors");
    end
    $finish;
  end

endmodule
